/* src/lsm_pkg.sv */
// Shared types, constants and helpers for the list-schedule makespan evaluator.
package lsm_pkg;

	localparam int TIME_W    = 32;
	localparam int TASK_W    = 8;
	localparam int PU_W      = 4;
	localparam int DUR_W     = 16;
	localparam int OVH_W     = 16;
	localparam int NUM_TASKS = 256;
	localparam int NUM_PUS   = 16;

	// Item codes; code 3 carries no meaning and is dropped
	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_PRED  = 2'd1,
		ACT_PLACE = 2'd2
	} lsm_action_t;

	// One entry of the per-task store
	typedef struct packed {
		logic [TIME_W-1:0] finish;
		logic [PU_W-1:0]   pu;
	} lsm_task_rec_t;

	// Write request into the per-task store
	typedef struct packed {
		logic              en;
		logic [TASK_W-1:0] addr;
		lsm_task_rec_t     rec;
	} lsm_task_wr_t;

	// Saturating add of two times
	function automatic logic [TIME_W-1:0] lsm_sat_add(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		logic [TIME_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
	endfunction

endpackage

/* src/list_schedule_makespan_core.sv */
// Top level of the list-schedule makespan evaluator.
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_stall    action, task_id, pu, duration, pred_id
//   out      out  out_valid / out_stall  done_task, start_time, finish_time,
//                                        makespan, flaw
//   cfg      in   cfg_write              cfg_data (communication overhead)
//
// One item per cycle unless a place item waits; its result is registered as it leaves stage 1.
// The task memory is read as an item is taken and the registered data used in stage 1;
// a place write in that same cycle is forwarded to the following predecessor.
// Reset and start items clear all schedule state at once, no sweep.
// A held result stalls only place items; other items keep flowing.
module list_schedule_makespan_core import lsm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [OVH_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        action,
	input  logic [TASK_W-1:0] task_id,
	input  logic [PU_W-1:0]   pu,
	input  logic [DUR_W-1:0]  duration,
	input  logic [TASK_W-1:0] pred_id,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [TASK_W-1:0] done_task,
	output logic [TIME_W-1:0] start_time,
	output logic [TIME_W-1:0] finish_time,
	output logic [TIME_W-1:0] makespan,
	output logic              flaw
);

	// Stage 1 item
	logic              s1_vld_q;
	logic [1:0]        act_s1;
	logic [TASK_W-1:0] task_s1;
	logic [PU_W-1:0]   pu_s1;
	logic [DUR_W-1:0]  dur_s1;
	logic [TASK_W-1:0] pred_s1;

	// Schedule state
	logic [OVH_W-1:0]  ovh_q;
	logic [TIME_W-1:0] ready_q [NUM_PUS];
	logic [TIME_W-1:0] arr_q;
	logic [TIME_W-1:0] span_q;
	logic              flaw_q;

	// Forwarding of the place write that coincides with a memory read
	logic              fwd_vld_q;
	logic [TASK_W-1:0] fwd_addr_q;
	lsm_task_rec_t     fwd_rec_q;

	// Output register
	logic              out_vld_q;
	logic [TASK_W-1:0] done_task_q;
	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] finish_q;
	logic [TIME_W-1:0] span_out_q;
	logic              flaw_out_q;

	logic              s1_fire;
	logic              in_xfer;
	logic              is_place;
	logic              is_start;
	lsm_task_wr_t      task_wr;
	lsm_task_rec_t     mem_rec;
	logic              mem_vld;
	logic              fwd_hit;
	lsm_task_rec_t     pred_rec;
	logic [TIME_W-1:0] pred_ft;
	logic [TIME_W-1:0] comm;
	logic [TIME_W-1:0] arr_new;
	logic [TIME_W-1:0] ready_cur;
	logic [TIME_W-1:0] st;
	logic [TIME_W-1:0] ft;
	logic [TIME_W-1:0] span_new;

	// Handshake: only a place item waits for the output register
	assign is_place = (act_s1 == ACT_PLACE);
	assign is_start = (act_s1 == ACT_START);
	assign s1_fire  = s1_vld_q && (!is_place || !out_vld_q || !out_stall);
	assign in_stall = s1_vld_q && !s1_fire;
	assign in_xfer  = in_valid && !in_stall;

	assign task_wr.en         = s1_fire && is_place;
	assign task_wr.addr       = task_s1;
	assign task_wr.rec.finish = ft;
	assign task_wr.rec.pu     = pu_s1;

	lsm_task_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (s1_fire && is_start),
		.wr       (task_wr),
		.rd_en    (in_xfer),
		.rd_addr  (pred_id),
		.vld_addr (pred_s1),
		.rd_rec   (mem_rec),
		.vld      (mem_vld)
	);

	// Predecessor arrival time
	always_comb begin
		fwd_hit  = fwd_vld_q && (fwd_addr_q == pred_s1);
		pred_rec = fwd_hit ? fwd_rec_q : mem_rec;
		pred_ft  = (fwd_hit || mem_vld) ? pred_rec.finish : '0;
		comm     = (pred_rec.pu != pu_s1) ? {{(TIME_W-OVH_W){1'b0}}, ovh_q} : '0;
		arr_new  = lsm_sat_add(pred_ft, comm);
	end

	// Placement: start, finish and running makespan
	always_comb begin
		ready_cur = ready_q[pu_s1];
		st        = (arr_q > ready_cur) ? arr_q : ready_cur;
		ft        = lsm_sat_add(st, {{(TIME_W-DUR_W){1'b0}}, dur_s1});
		span_new  = (ft > span_q) ? ft : span_q;
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			act_s1  <= action;
			task_s1 <= task_id;
			pu_s1   <= pu;
			dur_s1  <= duration;
			pred_s1 <= pred_id;
		end
	end

	// Control and schedule state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q  <= 1'b0;
			ovh_q     <= '0;
			ready_q   <= '{default: '0};
			arr_q     <= '0;
			span_q    <= '0;
			flaw_q    <= 1'b0;
			fwd_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				ovh_q <= cfg_data;
			end
			if (in_xfer) begin
				s1_vld_q  <= 1'b1;
				fwd_vld_q <= s1_fire && is_place;
			end else if (s1_fire) begin
				s1_vld_q <= 1'b0;
			end
			if (s1_fire) begin
				unique case (act_s1)
					ACT_START: begin
						ready_q <= '{default: '0};
						arr_q   <= '0;
						span_q  <= '0;
						flaw_q  <= 1'b0;
					end
					ACT_PRED: begin
						if (pred_ft == '0) begin
							flaw_q <= 1'b1;
						end else if (arr_new > arr_q) begin
							arr_q <= arr_new;
						end
					end
					ACT_PLACE: begin
						ready_q[pu_s1] <= ft;
						span_q         <= span_new;
						arr_q          <= '0;
					end
					default: begin
					end
				endcase
			end
			if (s1_fire && is_place) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Forwarded record and result payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			fwd_addr_q <= task_s1;
			fwd_rec_q  <= task_wr.rec;
		end
		if (s1_fire && is_place) begin
			done_task_q <= task_s1;
			start_q     <= st;
			finish_q    <= ft;
			span_out_q  <= flaw_q ? {TIME_W{1'b1}} : span_new;
			flaw_out_q  <= flaw_q;
		end
	end

	assign out_valid   = out_vld_q;
	assign done_task   = done_task_q;
	assign start_time  = start_q;
	assign finish_time = finish_q;
	assign makespan    = span_out_q;
	assign flaw        = flaw_out_q;

	// A flawed schedule always reports an all-ones makespan
	a_flaw_span: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && flaw |-> makespan == {TIME_W{1'b1}})
		else $error("flaw set but makespan not all ones");

	// Saturating sums never finish before they start
	a_finish_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> finish_time >= start_time)
		else $error("finish time below start time");

	// A start item leaves a clean schedule behind
	a_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && is_start |=> span_q == '0 && arr_q == '0 && !flaw_q)
		else $error("schedule state not cleared by start");

endmodule

/* src/lsm_task_store.sv */
// Per-task finish time and processor memory with clearable valid bits.
module lsm_task_store import lsm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clr,
	input  lsm_task_wr_t      wr,
	input  logic              rd_en,
	input  logic [TASK_W-1:0] rd_addr,
	input  logic [TASK_W-1:0] vld_addr,
	output lsm_task_rec_t     rd_rec,
	output logic              vld
);

	lsm_task_rec_t        mem [NUM_TASKS];
	lsm_task_rec_t        rd_rec_q;
	logic [NUM_TASKS-1:0] vld_q;

	// Synchronous memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.rec;
		end
		if (rd_en) begin
			rd_rec_q <= mem[rd_addr];
		end
	end

	// Valid bits: a start clears them all at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clr) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.addr] <= 1'b1;
		end
	end

	assign rd_rec = rd_rec_q;
	assign vld    = vld_q[vld_addr];

endmodule

/* test/tb_list_schedule_makespan_core.sv */
// Self-checking testbench for the list-schedule makespan evaluator core.
`timescale 1ns / 1ps

module tb_list_schedule_makespan_core;
	import lsm_pkg::*;

	localparam int CLK_PERIOD  = 10;
	localparam int RESET_TICKS = 12;
	localparam int SETTLE      = 6;     // cycles for the pipeline to empty after the last result
	localparam int LONG_HOLD   = 60;    // receiver hold-off that backs up place items
	localparam int QUIET_LIMIT = 2000;  // cycles without any transfer before giving up
	localparam int CHAIN_LEN   = 16;    // tasks in the closing dependency chain

	// action code 3 has no meaning and must be dropped by the block
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]        act;
		logic [TASK_W-1:0] tid;
		logic [PU_W-1:0]   pu_n;
		logic [DUR_W-1:0]  dur;
		logic [TASK_W-1:0] pid;
	} sched_item_t;

	typedef struct packed {
		logic [TASK_W-1:0] tid;
		logic [TIME_W-1:0] t_start;
		logic [TIME_W-1:0] t_finish;
		logic [TIME_W-1:0] span;
		logic              flawed;
	} placement_t;

	typedef struct packed {
		sched_item_t it;
		logic        typed;   // expected placement written by hand
		placement_t  want;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_write;
	logic [OVH_W-1:0]  cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        action;
	logic [TASK_W-1:0] task_id;
	logic [PU_W-1:0]   pu;
	logic [DUR_W-1:0]  duration;
	logic [TASK_W-1:0] pred_id;
	logic              out_valid;
	logic              out_stall;
	logic [TASK_W-1:0] done_task;
	logic [TIME_W-1:0] start_time;
	logic [TIME_W-1:0] finish_time;
	logic [TIME_W-1:0] makespan;
	logic              flaw;

	// schedule state as the block should hold it
	logic [TIME_W-1:0] fin_time [NUM_TASKS];
	logic [PU_W-1:0]   task_pu  [NUM_TASKS];
	logic [TIME_W-1:0] pu_ready [NUM_PUS];
	logic [TIME_W-1:0] data_arrival;
	logic [TIME_W-1:0] span_now;
	logic              span_flaw;
	logic [OVH_W-1:0]  ovh;

	placement_t        placements_due[$];
	logic [TASK_W-1:0] known_ids[$];     // tasks placed since the last start
	int                errors = 0;
	bit                hold_req = 1'b0;
	int                tx_left = 0;
	bit                tx_calm = 1'b0;

	list_schedule_makespan_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.task_id     (task_id),
		.pu          (pu),
		.duration    (duration),
		.pred_id     (pred_id),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.done_task   (done_task),
		.start_time  (start_time),
		.finish_time (finish_time),
		.makespan    (makespan),
		.flaw        (flaw)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// saturating time addition: overflow iff a exceeds the headroom left by b
	function automatic logic [TIME_W-1:0] time_sum(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		return (a > ~b) ? '1 : a + b;
	endfunction

	function automatic void clear_schedule_state();
		foreach (fin_time[i]) fin_time[i] = '0;
		foreach (pu_ready[i]) pu_ready[i] = '0;
		data_arrival = '0;
		span_now     = '0;
		span_flaw    = 1'b0;
	endfunction

	// Advance the schedule by one item; returns 1 when a placement is produced
	function automatic bit evaluate_item(input sched_item_t it, output placement_t res);
		logic [TIME_W-1:0] hop;
		logic [TIME_W-1:0] t_go;
		logic [TIME_W-1:0] t_end;
		res = '0;
		if (it.act == ACT_START) begin
			clear_schedule_state();
			return 1'b0;
		end
		if (it.act == ACT_PRED) begin
			// an unfinished predecessor taints the whole schedule
			if (fin_time[it.pid] == '0) begin
				span_flaw = 1'b1;
			end else begin
				hop = (task_pu[it.pid] != it.pu_n) ? TIME_W'(ovh) : '0;
				hop = time_sum(fin_time[it.pid], hop);
				if (hop > data_arrival)
					data_arrival = hop;
			end
			return 1'b0;
		end
		if (it.act != ACT_PLACE)
			return 1'b0;
		t_go = pu_ready[it.pu_n];
		if (data_arrival > t_go)
			t_go = data_arrival;
		t_end = time_sum(t_go, TIME_W'(it.dur));
		pu_ready[it.pu_n] = t_end;
		fin_time[it.tid]  = t_end;
		task_pu[it.tid]   = it.pu_n;
		if (t_end > span_now)
			span_now = t_end;
		data_arrival = '0;
		res.tid      = it.tid;
		res.t_start  = t_go;
		res.t_finish = t_end;
		res.span     = span_flaw ? '1 : span_now;
		res.flawed   = span_flaw;
		return 1'b1;
	endfunction

	function automatic dir_row_t plain(input logic [1:0] a, input logic [TASK_W-1:0] t,
		input logic [PU_W-1:0] p, input logic [DUR_W-1:0] d, input logic [TASK_W-1:0] q);
		dir_row_t r;
		r = '0;
		r.it = '{a, t, p, d, q};
		return r;
	endfunction

	function automatic dir_row_t known(input logic [1:0] a, input logic [TASK_W-1:0] t,
		input logic [PU_W-1:0] p, input logic [DUR_W-1:0] d, input logic [TASK_W-1:0] q,
		input logic [TIME_W-1:0] st, input logic [TIME_W-1:0] ft,
		input logic [TIME_W-1:0] ms, input logic fl);
		dir_row_t r;
		r = plain(a, t, p, d, q);
		r.typed = 1'b1;
		r.want  = '{t, st, ft, ms, fl};
		return r;
	endfunction

	// Offer one item after a random gap and hold it until the transfer
	task automatic push_item(input dir_row_t r);
		int         gap;
		placement_t res;
		if (tx_left == 0) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			tx_left = 40;
		end
		tx_left--;
		gap = tx_calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= r.it.act;
		task_id  <= r.it.tid;
		pu       <= r.it.pu_n;
		duration <= r.it.dur;
		pred_id  <= r.it.pid;
		do @(posedge clk); while (!(in_valid && !in_stall));
		if (evaluate_item(r.it, res))
			placements_due = {placements_due, (r.typed ? r.want : res)};
	endtask

	// Stop offering until every placement is back and the pipeline is empty
	task automatic drain();
		in_valid <= 1'b0;
		while (placements_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_overhead(input logic [OVH_W-1:0] v);
		cfg_write <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		cfg_write <= 1'b0;
		ovh = v;
	endtask

	// Mostly well-formed tasks (predecessors then a place) plus some noise
	task automatic run_random(input int n_items);
		int                sent;
		int                n_pred;
		int                roll;
		bit                asked_hold;
		bit                drained;
		logic [PU_W-1:0]   p;
		logic [TASK_W-1:0] t;
		logic [DUR_W-1:0]  d;
		sent       = 0;
		asked_hold = 1'b0;
		drained    = 1'b0;
		while (sent < n_items) begin
			if (!asked_hold && sent >= n_items / 3) begin
				hold_req   = 1'b1;
				asked_hold = 1'b1;
			end
			if (!drained && sent >= (2 * n_items) / 3) begin
				drain();
				drained = 1'b1;
			end
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				push_item(plain(ACT_START, TASK_W'($urandom), PU_W'($urandom),
					DUR_W'($urandom), TASK_W'($urandom)));
				known_ids.delete();
				sent++;
			end else if (roll < 7) begin
				push_item(plain(ACT_UNUSED, TASK_W'($urandom), PU_W'($urandom),
					DUR_W'($urandom), TASK_W'($urandom)));
			end else if (roll < 10) begin
				// stray predecessor, often one never placed
				push_item(plain(ACT_PRED, TASK_W'($urandom), PU_W'($urandom),
					DUR_W'($urandom), TASK_W'($urandom)));
				sent++;
			end else begin
				// a narrow processor range makes same-processor hops common
				p = ($urandom_range(0, 2) == 0) ? PU_W'($urandom_range(0, 1)) : PU_W'($urandom);
				n_pred = (known_ids.size() == 0) ? 0 : $urandom_range(0, 3);
				repeat (n_pred)
					push_item(plain(ACT_PRED, TASK_W'($urandom), p, DUR_W'($urandom),
						known_ids[$urandom_range(0, known_ids.size() - 1)]));
				t = TASK_W'($urandom);
				d = ($urandom_range(0, 1) == 0) ? DUR_W'($urandom_range(0, 20)) : DUR_W'($urandom);
				push_item(plain(ACT_PLACE, t, p, d, TASK_W'($urandom)));
				known_ids = {known_ids, t};
				sent += n_pred + 1;
			end
		end
	endtask

	// Receiver: random stall before each transfer, one long hold-off on request
	initial begin : sink
		int hold;
		int left;
		bit calm;
		left = 0;
		calm = 1'b0;
		out_stall = 1'b0;
		forever begin
			if (left == 0) begin
				calm = ($urandom_range(0, 3) == 0);
				left = 30;
			end
			left--;
			hold = calm ? 0 : $urandom_range(0, 3);
			if (hold_req) begin
				hold     = LONG_HOLD;
				hold_req = 1'b0;
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// Compare every result transfer with the oldest expected placement
	always @(posedge clk) begin : check_out
		placement_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (placements_due.size() == 0) begin
				$error("unexpected result for task %0d", done_task);
				errors++;
			end else begin
				want = placements_due.pop_front();
				if (done_task !== want.tid) begin
					$error("done_task: expected %0d, got %0d", want.tid, done_task);
					errors++;
				end
				if (start_time !== want.t_start) begin
					$error("start_time: expected %0d, got %0d", want.t_start, start_time);
					errors++;
				end
				if (finish_time !== want.t_finish) begin
					$error("finish_time: expected %0d, got %0d", want.t_finish, finish_time);
					errors++;
				end
				if (makespan !== want.span) begin
					$error("makespan: expected %0d, got %0d", want.span, makespan);
					errors++;
				end
				if (flaw !== want.flawed) begin
					$error("flaw: expected %0d, got %0d", want.flawed, flaw);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		dir_row_t rows[$];
		int       k;
		arst_n    = 1'b0;
		cfg_write = 1'b0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		action    = ACT_START;
		task_id   = '0;
		pu        = '0;
		duration  = '0;
		pred_id   = '0;
		ovh       = '0;
		foreach (task_pu[i]) task_pu[i] = '0;
		clear_schedule_state();

		// directed table, run with the reset value of the overhead
		rows = {rows, known(ACT_PLACE, 8'd0, 4'd0, 16'd0, 8'd0, 0, 0, 0, 1'b0)};
		rows = {rows, known(ACT_PLACE, 8'd255, 4'd15, 16'hFFFF, 8'd0, 0, 65535, 65535, 1'b0)};
		rows = {rows, plain(ACT_UNUSED, 8'd255, 4'd15, 16'hFFFF, 8'd255)};
		rows = {rows, plain(ACT_PRED, 8'd0, 4'd0, 16'd0, 8'd255)};
		rows = {rows, known(ACT_PLACE, 8'd1, 4'd0, 16'd1, 8'd0, 65535, 65536, 65536, 1'b0)};
		rows = {rows, plain(ACT_PRED, 8'd0, 4'd0, 16'd0, 8'd1)};
		rows = {rows, plain(ACT_PRED, 8'd0, 4'd0, 16'd0, 8'd255)};
		rows = {rows, plain(ACT_PLACE, 8'd2, 4'd15, 16'd100, 8'd0)};
		rows = {rows, plain(ACT_PLACE, 8'd3, 4'd15, 16'd0, 8'd0)};
		rows = {rows, plain(ACT_PRED, 8'd0, 4'd7, 16'd0, 8'd3)};
		// predecessor never placed: flaw from here on
		rows = {rows, plain(ACT_PRED, 8'd0, 4'd7, 16'd0, 8'd200)};
		rows = {rows, known(ACT_PLACE, 8'd4, 4'd7, 16'd5, 8'd0, 65636, 65641,
			32'hFFFF_FFFF, 1'b1)};
		rows = {rows, plain(ACT_PLACE, 8'd5, 4'd8, 16'd8, 8'd0)};
		rows = {rows, plain(ACT_START, 8'd255, 4'd15, 16'hFFFF, 8'd255)};
		// finish times cleared by the start
		rows = {rows, plain(ACT_PRED, 8'd0, 4'd0, 16'd0, 8'd255)};
		rows = {rows, plain(ACT_START, 8'd0, 4'd0, 16'd0, 8'd0)};
		rows = {rows, known(ACT_PLACE, 8'd6, 4'd15, 16'd3, 8'd0, 0, 3, 3, 1'b0)};
		rows = {rows, plain(ACT_PRED, 8'd0, 4'd15, 16'd0, 8'd6)};
		rows = {rows, plain(ACT_PLACE, 8'd7, 4'd15, 16'hFFFF, 8'd0)};
		// placed with finish zero, then used as a predecessor
		rows = {rows, plain(ACT_PLACE, 8'd8, 4'd9, 16'd0, 8'd0)};
		rows = {rows, plain(ACT_PRED, 8'd0, 4'd9, 16'd0, 8'd8)};
		rows = {rows, plain(ACT_PLACE, 8'd9, 4'd9, 16'hFFFF, 8'd0)};
		rows = {rows, plain(ACT_START, 8'd0, 4'd0, 16'd0, 8'd0)};
		rows = {rows, plain(ACT_UNUSED, 8'd0, 4'd0, 16'd0, 8'd0)};
		rows = {rows, known(ACT_PLACE, 8'd10, 4'd1, 16'd2, 8'd0, 0, 2, 2, 1'b0)};

		repeat (RESET_TICKS) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) push_item(rows[i]);
		drain();

		// random phases over a spread of overhead settings
		write_overhead('1);
		run_random(85);
		drain();
		write_overhead('0);
		run_random(85);
		drain();
		write_overhead(OVH_W'($urandom_range(1, 65534)));
		run_random(85);
		drain();
		write_overhead(OVH_W'(1));
		run_random(85);
		drain();

		// chain of tasks alternating between two processors,
		// each waiting for its predecessor plus the largest overhead
		write_overhead('1);
		push_item(plain(ACT_START, 8'd0, 4'd0, 16'd0, 8'd0));
		for (k = 0; k < CHAIN_LEN; k++) begin
			if (k > 0)
				push_item(plain(ACT_PRED, 8'd0, PU_W'(k % 2), 16'd0, TASK_W'(k - 1)));
			push_item(plain(ACT_PLACE, TASK_W'(k), PU_W'(k % 2), 16'hFFFF, 8'd0));
		end
		drain();

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
